// ----- rtl/ltp_pkg.sv -----
package ltp_pkg;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned STAMP_W = 64;
  localparam int unsigned HINT_W  = 8;
  localparam int unsigned SLOT_W  = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HINT,
    ST_SCAN,
    ST_FINISH
  } ltp_state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic hint_chk;
    logic scan;
    logic commit;
  } ltp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hint_hit;
    logic scan_last;
  } ltp_sts_t;

endpackage

// ----- rtl/ltp_if.sv -----
interface ltp_req_if import ltp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  hash_key;
  logic [HINT_W-1:0] hint_slot;

  modport source (output valid, output hash_key, output hint_slot, input ready);
  modport sink   (input valid, input hash_key, input hint_slot, output ready);
endinterface

interface ltp_rsp_if import ltp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot;
  logic              hit;

  modport source (output valid, output slot, output hit, input ready);
  modport sink   (input valid, input slot, input hit, output ready);
endinterface

// ----- rtl/ltp_ram.sv -----
module ltp_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ltp_ctrl.sv -----
module ltp_ctrl import ltp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  output logic     rsp_valid_o,
  input  logic     rsp_ready_i,
  input  ltp_sts_t sts_i,
  output ltp_cmd_t cmd_o
);

  ltp_state_e state_q, state_d;
  logic       out_vld_q, out_vld_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) state_d = ST_HINT;
      end
      ST_HINT: begin
        state_d = sts_i.hint_hit ? ST_FINISH : ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.scan_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_vld_q || rsp_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o  = 1'b1;
        cmd_o.accept = req_valid_i;
      end
      ST_HINT:   cmd_o.hint_chk = 1'b1;
      ST_SCAN:   cmd_o.scan     = 1'b1;
      ST_FINISH: cmd_o.commit   = !out_vld_q || rsp_ready_i;
      default: ;
    endcase
  end

  // hold the result until the sink takes it
  always_comb begin
    out_vld_d = out_vld_q;
    if (rsp_ready_i) out_vld_d = 1'b0;
    if (cmd_o.commit) out_vld_d = 1'b1;
  end

  assign rsp_valid_o = out_vld_q;

endmodule

// ----- rtl/ltp_dpath.sv -----
module ltp_dpath import ltp_pkg::*; #(
  parameter int unsigned SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ltp_cmd_t          cmd_i,
  output ltp_sts_t          sts_o,
  input  logic [KEY_W-1:0]  hash_key_i,
  input  logic [HINT_W-1:0] hint_slot_i,
  output logic [SLOT_W-1:0] slot_o,
  output logic              hit_o
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [KEY_W-1:0]   key_q;
  logic [IDX_W-1:0]   hint_idx_q;
  logic               hint_ok_q;
  logic               hint_hit_q;
  logic [IDX_W-1:0]   cnt_q;
  logic               match_fnd_q, emp_fnd_q;
  logic [IDX_W-1:0]   match_idx_q, emp_idx_q, vict_idx_q;
  logic [STAMP_W-1:0] least_q;
  logic [STAMP_W-1:0] use_clk_q;
  logic [SLOTS-1:0]   vld_q;
  logic               rd_vld_q;
  logic [SLOT_W-1:0]  slot_q;
  logic               hit_q;

  logic               hint_ok;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   sel_idx;
  logic [KEY_W-1:0]   tag_rdata, tag_rd;
  logic [STAMP_W-1:0] stamp_rdata, stamp_rd;
  logic [STAMP_W-1:0] stamp_next;
  logic               scan_last;

  assign hint_ok   = hint_slot_i < HINT_W'(SLOTS);
  assign scan_last = cnt_q == IDX_W'(SLOTS - 1);

  // read address: hint on accept, then slot 0 upward
  always_comb begin
    if (cmd_i.accept) begin
      rd_addr = hint_ok ? hint_slot_i[IDX_W-1:0] : '0;
    end else if (cmd_i.hint_chk || scan_last) begin
      rd_addr = '0;
    end else begin
      rd_addr = cnt_q + IDX_W'(1);
    end
  end

  // never-written slots read as zero
  assign tag_rd   = rd_vld_q ? tag_rdata : '0;
  assign stamp_rd = rd_vld_q ? stamp_rdata : '0;

  always_comb begin
    if (hint_hit_q)       sel_idx = hint_idx_q;
    else if (match_fnd_q) sel_idx = match_idx_q;
    else if (emp_fnd_q)   sel_idx = emp_idx_q;
    else                  sel_idx = vict_idx_q;
  end

  assign stamp_next = use_clk_q + STAMP_W'(1);

  ltp_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit),
    .waddr_i (sel_idx),
    .wdata_i (key_q),
    .raddr_i (rd_addr),
    .rdata_o (tag_rdata)
  );

  ltp_ram #(.WIDTH(STAMP_W), .DEPTH(SLOTS)) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit),
    .waddr_i (sel_idx),
    .wdata_i (stamp_next),
    .raddr_i (rd_addr),
    .rdata_o (stamp_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      use_clk_q   <= '0;
      hint_hit_q  <= 1'b0;
      match_fnd_q <= 1'b0;
      emp_fnd_q   <= 1'b0;
      cnt_q       <= '0;
    end else begin
      rd_vld_q <= vld_q[rd_addr];
      if (cmd_i.hint_chk) begin
        hint_hit_q  <= hint_ok_q && (tag_rd == key_q);
        match_fnd_q <= 1'b0;
        emp_fnd_q   <= 1'b0;
        cnt_q       <= '0;
      end
      if (cmd_i.scan) begin
        if (!match_fnd_q && tag_rd == key_q) match_fnd_q <= 1'b1;
        if (!emp_fnd_q && tag_rd == '0) emp_fnd_q <= 1'b1;
        if (!scan_last) cnt_q <= cnt_q + IDX_W'(1);
      end
      if (cmd_i.commit) begin
        vld_q[sel_idx] <= 1'b1;
        use_clk_q      <= stamp_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      key_q      <= hash_key_i;
      hint_idx_q <= hint_slot_i[IDX_W-1:0];
      hint_ok_q  <= hint_ok;
    end
    if (cmd_i.hint_chk) begin
      least_q    <= '1;
      vict_idx_q <= '0;
    end
    if (cmd_i.scan) begin
      if (!match_fnd_q && tag_rd == key_q) match_idx_q <= cnt_q;
      if (!emp_fnd_q && tag_rd == '0) emp_idx_q <= cnt_q;
      if (stamp_rd < least_q) begin
        least_q    <= stamp_rd;
        vict_idx_q <= cnt_q;
      end
    end
    if (cmd_i.commit) begin
      slot_q <= SLOT_W'(sel_idx);
      hit_q  <= hint_hit_q || match_fnd_q;
    end
  end

  assign sts_o.hint_hit  = hint_ok_q && (tag_rd == key_q);
  assign sts_o.scan_last = scan_last;
  assign slot_o          = slot_q;
  assign hit_o           = hit_q;

endmodule

// ----- rtl/lru_tag_pool_lookup.sv -----
// Fully associative tag pool with least-recently-used replacement.
//
// req_i (sink): a 64-bit hash_key and an 8-bit hint_slot. rsp_o (source):
// the slot now holding the key and a hit flag. Both channels transfer on
// valid && ready.
//
// One request is processed at a time. A request whose hint slot holds the
// key skips the scan and goes from the hint check straight to the update,
// and the next request is taken once the update is done. Otherwise the tag
// and stamp memories are scanned one slot per cycle through their single
// read port before the update, which loads the result register.
//
// Reset empties every slot (per-slot valid flags, no clearing pass) and
// zeroes the use clock. A result waits in an output register while the
// sink stalls; the next request is still accepted and scanned, and it
// holds before its update until that register is free.
module lru_tag_pool_lookup import ltp_pkg::*; #(
  parameter int unsigned SLOTS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ltp_req_if.sink    req_i,
  ltp_rsp_if.source  rsp_o
);

  ltp_cmd_t cmd;
  ltp_sts_t sts;

  ltp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ltp_dpath #(.SLOTS(SLOTS)) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .hash_key_i  (req_i.hash_key),
    .hint_slot_i (req_i.hint_slot),
    .slot_o      (rsp_o.slot),
    .hit_o       (rsp_o.hit)
  );

endmodule

// ----- rtl/ltp_checker.sv -----
module ltp_checker import ltp_pkg::*; #(
  parameter int unsigned SLOTS = 16
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic [SLOT_W-1:0] rsp_slot_i
);

  logic       req_xfer, rsp_xfer;
  logic [1:0] pend_q;

  assign req_xfer = req_valid_i && req_ready_i;
  assign rsp_xfer = rsp_valid_i && rsp_ready_i;

  // requests taken minus results delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(req_xfer) - 2'(rsp_xfer);
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  a_rsp_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pend_q != 2'd0)
    else $error("result without a pending request");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many requests in flight");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_xfer |=> !req_ready_i)
    else $error("request taken while one is being processed");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (SLOTS >= 16) || (32'(rsp_slot_i) < SLOTS))
    else $error("result slot outside the pool");

endmodule

bind lru_tag_pool_lookup ltp_checker #(.SLOTS(SLOTS)) u_ltp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_slot_i  (rsp_o.slot)
);
